@@ src/skot_pkg.sv @@
package skot_pkg;

    localparam int DEPTH  = 64;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int USED_W = $clog2(DEPTH + 1);
    localparam int KEY_W  = 24;
    localparam int TAG_W  = 16;
    localparam int CNT_W  = 32;
    localparam int CMD_W  = 2;

    localparam logic [CMD_W-1:0] CMD_RECORD = 2'd0;
    localparam logic [CMD_W-1:0] CMD_READ   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

    typedef struct packed {
        logic             cmp_en;
        logic             upd_en;
        logic [CMD_W-1:0] cmd;
        logic [KEY_W-1:0] key;
        logic [TAG_W-1:0] tag;
        logic [IDX_W-1:0] idx;
        logic             hit_any;
        logic             full;
    } cell_ctrl_t;

    typedef struct packed {
        logic             valid;
        logic             gt;
        logic [KEY_W-1:0] key;
        logic [CNT_W-1:0] count;
        logic [TAG_W-1:0] tag;
    } cell_link_t;

    typedef struct packed {
        logic             sel;
        logic [KEY_W-1:0] key;
        logic [CNT_W-1:0] count;
        logic [TAG_W-1:0] tag;
    } cell_view_t;

endpackage

@@ src/skot_cell.sv @@
module skot_cell (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [skot_pkg::IDX_W-1:0] self_idx,
    input  skot_pkg::cell_ctrl_t       ctrl,
    input  skot_pkg::cell_link_t       left,
    output skot_pkg::cell_link_t       link,
    output logic                       eq,
    output skot_pkg::cell_view_t       view
);
    import skot_pkg::*;

    logic             valid_reg;
    logic             eq_reg;
    logic             gt_reg;
    logic             rd_reg;
    logic             sel_reg;
    logic [KEY_W-1:0] key_reg;
    logic [CNT_W-1:0] count_reg;
    logic [TAG_W-1:0] tag_reg;

    logic             left_le;
    logic             here;
    logic             shift;
    logic             insert_ok;
    logic [CNT_W-1:0] count_inc;

    assign left_le   = left.valid & ~left.gt;
    assign here      = left_le & (gt_reg | ~valid_reg);
    assign shift     = left.gt;
    assign insert_ok = ~ctrl.hit_any & ~ctrl.full;
    assign count_inc = (&count_reg) ? count_reg : count_reg + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            eq_reg    <= 1'b0;
            gt_reg    <= 1'b0;
            rd_reg    <= 1'b0;
            sel_reg   <= 1'b0;
        end
        else
        begin
            if (ctrl.cmp_en)
            begin
                eq_reg <= valid_reg && (key_reg == ctrl.key);
                gt_reg <= valid_reg && (key_reg > ctrl.key);
                rd_reg <= valid_reg && (self_idx == ctrl.idx);
            end
            if (ctrl.upd_en)
            begin
                unique case (ctrl.cmd)
                    CMD_RECORD:
                    begin
                        if (ctrl.hit_any)
                        begin
                            sel_reg <= eq_reg;
                        end
                        else if (insert_ok)
                        begin
                            sel_reg <= here;
                            if (here || shift)
                            begin
                                valid_reg <= 1'b1;
                            end
                        end
                        else
                        begin
                            sel_reg <= 1'b0;
                        end
                    end
                    CMD_READ:
                    begin
                        sel_reg <= rd_reg;
                    end
                    CMD_CLEAR:
                    begin
                        sel_reg   <= 1'b0;
                        valid_reg <= 1'b0;
                    end
                    default:
                    begin
                        sel_reg <= 1'b0;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.upd_en && (ctrl.cmd == CMD_RECORD))
        begin
            if (ctrl.hit_any && eq_reg)
            begin
                count_reg <= count_inc;
            end
            else if (insert_ok && shift)
            begin
                key_reg   <= left.key;
                count_reg <= left.count;
                tag_reg   <= left.tag;
            end
            else if (insert_ok && here)
            begin
                key_reg   <= ctrl.key;
                count_reg <= CNT_W'(1);
                tag_reg   <= ctrl.tag;
            end
        end
    end

    assign link.valid = valid_reg;
    assign link.gt    = gt_reg;
    assign link.key   = key_reg;
    assign link.count = count_reg;
    assign link.tag   = tag_reg;

    assign eq = eq_reg;

    assign view.sel   = sel_reg;
    assign view.key   = sel_reg ? key_reg : '0;
    assign view.count = sel_reg ? count_reg : '0;
    assign view.tag   = sel_reg ? tag_reg : '0;

endmodule

@@ src/skot_gather.sv @@
module skot_gather (
    input  logic                       clk,
    input  logic                       en,
    input  skot_pkg::cell_view_t       views [skot_pkg::DEPTH],
    output logic [skot_pkg::IDX_W-1:0] pos,
    output logic [skot_pkg::KEY_W-1:0] key,
    output logic [skot_pkg::CNT_W-1:0] count,
    output logic [skot_pkg::TAG_W-1:0] tag
);
    import skot_pkg::*;

    logic [IDX_W-1:0] pos_reg;
    logic [KEY_W-1:0] key_reg;
    logic [CNT_W-1:0] count_reg;
    logic [TAG_W-1:0] tag_reg;

    logic [IDX_W-1:0] pos_next;
    logic [KEY_W-1:0] key_next;
    logic [CNT_W-1:0] count_next;
    logic [TAG_W-1:0] tag_next;

    always_comb
    begin
        pos_next   = '0;
        key_next   = '0;
        count_next = '0;
        tag_next   = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (views[i].sel)
            begin
                pos_next = pos_next | IDX_W'(i);
            end
            key_next   = key_next | views[i].key;
            count_next = count_next | views[i].count;
            tag_next   = tag_next | views[i].tag;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pos_reg   <= pos_next;
            key_reg   <= key_next;
            count_reg <= count_next;
            tag_reg   <= tag_next;
        end
    end

    assign pos   = pos_reg;
    assign key   = key_reg;
    assign count = count_reg;
    assign tag   = tag_reg;

endmodule

@@ src/sorted_key_occurrence_table.sv @@
// Sorted key occurrence table built as a row of compare-and-shift cells.
// Each accepted word passes through the compare, update, gather and output load
// states in order, and no new word is taken until its result word is loaded;
// the output load waits while a previous result word is still held.
// Reset (rst_n, async, active low) empties the table and clears both channels.
module sorted_key_occurrence_table (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [skot_pkg::CMD_W-1:0]  cmd,
    input  logic [skot_pkg::KEY_W-1:0]  key,
    input  logic [skot_pkg::TAG_W-1:0]  tag,
    input  logic [skot_pkg::IDX_W-1:0]  index,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [skot_pkg::IDX_W-1:0]  position,
    output logic                        found,
    output logic [skot_pkg::CNT_W-1:0]  occurrences,
    output logic [skot_pkg::KEY_W-1:0]  entry_key,
    output logic [skot_pkg::TAG_W-1:0]  entry_tag,
    output logic                        dropped,
    output logic                        entry_valid,
    output logic [skot_pkg::USED_W-1:0] used
);
    import skot_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_CMP  = 3'd1;
    localparam logic [2:0] ST_UPD  = 3'd2;
    localparam logic [2:0] ST_GTH  = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    logic [2:0]        state_reg;
    logic [CMD_W-1:0]  cmd_reg;
    logic [KEY_W-1:0]  key_reg;
    logic [TAG_W-1:0]  tag_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic [USED_W-1:0] used_reg;
    logic              found_reg;
    logic              dropped_reg;
    logic              evalid_reg;

    logic              out_valid_reg;
    logic [IDX_W-1:0]  position_reg;
    logic              found_out_reg;
    logic [CNT_W-1:0]  occurrences_reg;
    logic [KEY_W-1:0]  entry_key_reg;
    logic [TAG_W-1:0]  entry_tag_reg;
    logic              dropped_out_reg;
    logic              entry_valid_reg;
    logic [USED_W-1:0] used_out_reg;

    cell_ctrl_t        ctrl;
    cell_link_t        links [DEPTH];
    cell_link_t        lefts [DEPTH];
    cell_view_t        views [DEPTH];
    logic [DEPTH-1:0]  eq_vec;
    logic [DEPTH-1:0]  sel_vec;
    logic [DEPTH-1:0]  valid_vec;

    logic              hit;
    logic              full;
    logic              accept;
    logic              load_out;

    logic [IDX_W-1:0]  gth_pos;
    logic [KEY_W-1:0]  gth_key;
    logic [CNT_W-1:0]  gth_count;
    logic [TAG_W-1:0]  gth_tag;

    assign hit      = |eq_vec;
    assign full     = (used_reg == USED_W'(DEPTH));
    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;
    assign load_out = (state_reg == ST_OUT) && (!out_valid_reg || out_ready);

    assign ctrl.cmp_en  = (state_reg == ST_CMP);
    assign ctrl.upd_en  = (state_reg == ST_UPD);
    assign ctrl.cmd     = cmd_reg;
    assign ctrl.key     = key_reg;
    assign ctrl.tag     = tag_reg;
    assign ctrl.idx     = idx_reg;
    assign ctrl.hit_any = hit;
    assign ctrl.full    = full;

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            if (gi == 0)
            begin : g_head
                assign lefts[gi] = '{valid: 1'b1, gt: 1'b0, key: '0, count: '0, tag: '0};
            end
            else
            begin : g_body
                assign lefts[gi] = links[gi-1];
            end

            skot_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .self_idx (IDX_W'(gi)),
                .ctrl     (ctrl),
                .left     (lefts[gi]),
                .link     (links[gi]),
                .eq       (eq_vec[gi]),
                .view     (views[gi])
            );

            assign sel_vec[gi]   = views[gi].sel;
            assign valid_vec[gi] = links[gi].valid;
        end
    endgenerate

    skot_gather u_gather (
        .clk   (clk),
        .en    (state_reg == ST_GTH),
        .views (views),
        .pos   (gth_pos),
        .key   (gth_key),
        .count (gth_count),
        .tag   (gth_tag)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg <= ST_CMP;
                    end
                end
                ST_CMP:  state_reg <= ST_UPD;
                ST_UPD:  state_reg <= ST_GTH;
                ST_GTH:  state_reg <= ST_OUT;
                ST_OUT:
                begin
                    if (load_out)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= cmd;
            key_reg <= key;
            tag_reg <= tag;
            idx_reg <= index;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg    <= '0;
            found_reg   <= 1'b0;
            dropped_reg <= 1'b0;
            evalid_reg  <= 1'b0;
        end
        else if (state_reg == ST_UPD)
        begin
            case (cmd_reg)
                CMD_RECORD:
                begin
                    found_reg   <= hit;
                    dropped_reg <= !hit && full;
                    evalid_reg  <= hit || !full;
                    if (!hit && !full)
                    begin
                        used_reg <= used_reg + 1'b1;
                    end
                end
                CMD_READ:
                begin
                    found_reg   <= 1'b0;
                    dropped_reg <= 1'b0;
                    evalid_reg  <= ({1'b0, idx_reg} < used_reg);
                end
                CMD_CLEAR:
                begin
                    used_reg    <= '0;
                    found_reg   <= 1'b0;
                    dropped_reg <= 1'b0;
                    evalid_reg  <= 1'b0;
                end
                default:
                begin
                    found_reg   <= 1'b0;
                    dropped_reg <= 1'b0;
                    evalid_reg  <= 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            position_reg    <= (cmd_reg == CMD_READ) ? idx_reg : gth_pos;
            found_out_reg   <= found_reg;
            occurrences_reg <= gth_count;
            entry_key_reg   <= gth_key;
            entry_tag_reg   <= gth_tag;
            dropped_out_reg <= dropped_reg;
            entry_valid_reg <= evalid_reg;
            used_out_reg    <= used_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign position    = position_reg;
    assign found       = found_out_reg;
    assign occurrences = occurrences_reg;
    assign entry_key   = entry_key_reg;
    assign entry_tag   = entry_tag_reg;
    assign dropped     = dropped_out_reg;
    assign entry_valid = entry_valid_reg;
    assign used        = used_out_reg;

`ifndef NO_ASSERTIONS
    a_sel_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_GTH) |-> $onehot0(sel_vec))
        else $error("more than one cell selected");

    a_used_range: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= USED_W'(DEPTH))
        else $error("entry count beyond table depth");

    a_head_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (valid_vec[0] == (used_reg != '0)))
        else $error("head cell occupancy disagrees with entry count");

    a_hit_no_grow: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_UPD) && (cmd_reg == CMD_RECORD) && hit) |=>
        (used_reg == $past(used_reg)))
        else $error("entry count changed on a hit");

    a_eq_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_UPD) |-> $onehot0(eq_vec))
        else $error("key stored in more than one cell");
`endif

endmodule
